/* rtl/core/psws_pkg.sv */
// Package with the constants, codes and types shared by the semaphore wait queue modules.
`default_nettype none

package psws_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int NUM_LEVELS  = 7;

  localparam int ID_W    = 6;
  localparam int PRIO_W  = 3;
  localparam int COUNT_W = 9;
  localparam int CFG_W   = 8;
  localparam int TOTAL_W = $clog2(MAX_WAITERS + 1);
  localparam int QIDX_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [PRIO_W-1:0] PRIO_LAST = PRIO_W'(NUM_LEVELS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_WAITERS);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -9'sd256;

  localparam logic MODE_WAIT   = 1'b0;
  localparam logic MODE_SIGNAL = 1'b1;

  localparam logic CFG_BINARY_MODE   = 1'b0;
  localparam logic CFG_INITIAL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INSERT,
    ST_DEQ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_WRITE,
    Q_POP
  } qop_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    qop_t              op;
    logic [QIDX_W-1:0] idx;
    entry_t            data;
  } qcmd_t;

  typedef struct packed {
    logic                       granted;
    logic                       blocked;
    logic                       woken_valid;
    entry_t                     woken;
    logic                       queue_full_error;
    logic [TOTAL_W-1:0]         waiters_now;
    logic signed [COUNT_W-1:0]  count_now;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/priority_semaphore_wait_queue_unit.sv */
// Top level of the priority semaphore wait queue with stream ports and result register.
//
// Channel  Direction  Handshake              Content
// in_      slave      in_tvalid / in_tready  one wait or signal request
// out_     master     out_tvalid/out_tready  one result per request
// cfg_     slave      cfg_valid / cfg_ready  register index and write data
//
// A granted wait, a full-queue wait or a signal goes from the decide state straight to done.
// A signal that wakes a thread passes through the dequeue state as well. A blocking wait
// walks the insert state, which moves every queued entry of lower urgency, one a cycle.
// Reset clears the count, the waiter total and the mode; queue contents need no reset.
// A result held by a stalled output lets the next request be accepted and worked on.
`default_nettype none

module priority_semaphore_wait_queue_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [psws_pkg::IN_TDATA_W-1:0]   in_tdata,   // thread_id, thread_priority
  input  wire logic                              in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // granted, blocked, woken_valid, woken_id, woken_priority, queue_full_error,
  // waiters_now, count_now
  output logic [psws_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [psws_pkg::CFG_W-1:0]        cfg_data
);
  import psws_pkg::*;

  entry_t              req_entry;
  qcmd_t               qcmd;
  logic [QIDX_W-1:0]   q_rd_idx;
  entry_t              q_rd_entry;
  entry_t              q_head;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  logic                out_valid_r;
  result_t             out_r;
  logic                cfg_we;

  assign req_entry.id   = in_tdata[ID_W-1:0];
  assign req_entry.prio = in_tdata[ID_W+PRIO_W-1:ID_W];
  assign cfg_ready      = 1'b1;
  assign cfg_we         = cfg_valid;
  assign res_ready      = !out_valid_r || out_tready;

  psws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_mode   (in_tuser),
    .req_entry  (req_entry),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .qcmd       (qcmd),
    .q_rd_idx   (q_rd_idx),
    .q_rd_entry (q_rd_entry),
    .q_head     (q_head),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  psws_queue u_queue (
    .clk      (clk),
    .cmd      (qcmd),
    .rd_idx   (q_rd_idx),
    .rd_entry (q_rd_entry),
    .head     (q_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.count_now, out_r.waiters_now, out_r.queue_full_error,
                       out_r.woken.prio, out_r.woken.id, out_r.woken_valid,
                       out_r.blocked, out_r.granted};

endmodule

`default_nettype wire

/* rtl/core/psws_queue.sv */
// Priority-ordered wait queue storage with one write port, one read port and a head pop.
`default_nettype none

module psws_queue (
  input  wire logic                     clk,
  input  wire psws_pkg::qcmd_t          cmd,
  input  wire logic [psws_pkg::QIDX_W-1:0] rd_idx,
  output psws_pkg::entry_t              rd_entry,
  output psws_pkg::entry_t              head
);
  import psws_pkg::*;

  entry_t slot_r [MAX_WAITERS];

  always_ff @(posedge clk) begin
    case (cmd.op)
      Q_WRITE: begin
        slot_r[cmd.idx] <= cmd.data;
      end
      Q_POP: begin
        for (int i = 0; i < MAX_WAITERS - 1; i++) begin
          slot_r[i] <= slot_r[i + 1];
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_entry = slot_r[rd_idx];
  assign head     = slot_r[0];

endmodule

`default_nettype wire

/* rtl/core/psws_ctrl.sv */
// Sequencer holding the semaphore count, the waiter total and the insertion walk.
`default_nettype none

module psws_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic                        req_mode,
  input  wire psws_pkg::entry_t            req_entry,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [psws_pkg::CFG_W-1:0]  cfg_val,
  output psws_pkg::qcmd_t                  qcmd,
  output logic [psws_pkg::QIDX_W-1:0]      q_rd_idx,
  input  wire psws_pkg::entry_t            q_rd_entry,
  input  wire psws_pkg::entry_t            q_head,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output psws_pkg::result_t                res
);
  import psws_pkg::*;

  state_t                     state_r, state_nxt;
  logic                       binary_r, binary_nxt;
  logic signed [COUNT_W-1:0]  count_r, count_nxt;
  logic [TOTAL_W-1:0]         total_r, total_nxt;
  logic [TOTAL_W-1:0]         k_r, k_nxt;
  logic                       sig_r, sig_nxt;
  entry_t                     new_r, new_nxt;
  logic                       granted_r, granted_nxt;
  logic                       blocked_r, blocked_nxt;
  logic                       err_r, err_nxt;
  logic                       wv_r, wv_nxt;
  entry_t                     woken_r, woken_nxt;

  logic [TOTAL_W-1:0]         k_dec;
  logic                       move_on;
  logic signed [COUNT_W-1:0]  count_up;
  logic signed [COUNT_W-1:0]  count_down;
  entry_t                     in_sat;

  assign k_dec    = k_r - TOTAL_W'(1);
  assign q_rd_idx = k_dec[QIDX_W-1:0];
  assign move_on  = (k_r != '0) && (q_rd_entry.prio > new_r.prio);
  assign count_up   = (count_r < COUNT_MAX) ? count_r + 9'sd1 : count_r;
  assign count_down = (count_r > COUNT_MIN) ? count_r - 9'sd1 : count_r;

  always_comb begin
    in_sat = req_entry;
    if (req_entry.prio > PRIO_LAST) begin
      in_sat.prio = PRIO_LAST;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sig_r == MODE_WAIT) begin
          if (count_r > 9'sd0 || total_r >= TOTAL_MAX) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_INSERT;
          end
        end else if (binary_r) begin
          state_nxt = (total_r == '0) ? ST_DONE : ST_DEQ;
        end else begin
          state_nxt = (count_up > 9'sd0 || total_r == '0) ? ST_DONE : ST_DEQ;
        end
      end
      ST_INSERT: begin
        if (!move_on) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DEQ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    binary_nxt  = binary_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    k_nxt       = k_r;
    sig_nxt     = sig_r;
    new_nxt     = new_r;
    granted_nxt = granted_r;
    blocked_nxt = blocked_r;
    err_nxt     = err_r;
    wv_nxt      = wv_r;
    woken_nxt   = woken_r;
    qcmd.op     = Q_NONE;
    qcmd.idx    = k_r[QIDX_W-1:0];
    qcmd.data   = new_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          sig_nxt     = req_mode;
          new_nxt     = in_sat;
          granted_nxt = 1'b0;
          blocked_nxt = 1'b0;
          err_nxt     = 1'b0;
          wv_nxt      = 1'b0;
          woken_nxt   = '0;
        end
      end
      ST_DECIDE: begin
        if (sig_r == MODE_WAIT) begin
          if (count_r > 9'sd0) begin
            count_nxt   = binary_r ? 9'sd0 : count_r - 9'sd1;
            granted_nxt = 1'b1;
          end else if (total_r >= TOTAL_MAX) begin
            err_nxt = 1'b1;
          end else begin
            if (!binary_r) begin
              count_nxt = count_down;
            end
            k_nxt = total_r;
          end
        end else if (binary_r) begin
          if (total_r == '0) begin
            count_nxt = 9'sd1;
          end
        end else begin
          count_nxt = count_up;
        end
      end
      ST_INSERT: begin
        qcmd.op = Q_WRITE;
        if (move_on) begin
          qcmd.data = q_rd_entry;
          k_nxt     = k_dec;
        end else begin
          total_nxt   = total_r + TOTAL_W'(1);
          blocked_nxt = 1'b1;
        end
      end
      ST_DEQ: begin
        qcmd.op   = Q_POP;
        wv_nxt    = 1'b1;
        woken_nxt = q_head;
        total_nxt = total_r - TOTAL_W'(1);
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      if (cfg_idx == CFG_BINARY_MODE) begin
        binary_nxt = cfg_val[0];
      end else begin
        count_nxt = signed'({1'b0, cfg_val});
        total_nxt = '0;
      end
    end
  end

  always_comb begin
    res.granted          = granted_r;
    res.blocked          = blocked_r;
    res.woken_valid      = wv_r;
    res.woken            = woken_r;
    res.queue_full_error = err_r;
    res.waiters_now      = total_r;
    res.count_now        = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      binary_r <= 1'b0;
      count_r  <= '0;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      binary_r <= binary_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    sig_r     <= sig_nxt;
    new_r     <= new_nxt;
    granted_r <= granted_nxt;
    blocked_r <= blocked_nxt;
    err_r     <= err_nxt;
    wv_r      <= wv_nxt;
    woken_r   <= woken_nxt;
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the priority semaphore wait queue unit.
`timescale 1ns / 100ps

module tb_top;
  import psws_pkg::*;

  localparam int SEM_CEIL      = 255;
  localparam int SEM_FLOOR     = -256;
  localparam int SYNC_SETTLE   = 8;
  localparam int END_SETTLE    = 40;
  localparam int HOLD_AT       = 80;
  localparam int HOLD_CYCLES   = 250;
  localparam int LIMIT_CYCLES  = 2000000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 120;

  typedef enum logic [1:0] {
    REQ_OP,
    REQ_CFG,
    REQ_SYNC
  } req_kind_t;

  typedef struct {
    req_kind_t         kind;
    logic              mode;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              cfg_idx;
    logic [CFG_W-1:0]  cfg_val;
  } sem_req_t;

  typedef struct packed {
    logic                      granted;
    logic                      blocked;
    logic                      woken_valid;
    logic [ID_W-1:0]           woken_id;
    logic [PRIO_W-1:0]         woken_prio;
    logic                      full_err;
    logic [TOTAL_W-1:0]        waiters_now;
    logic signed [COUNT_W-1:0] count_now;
  } sem_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;

  sem_req_t    request_q[$];
  sem_result_t outcome_q[$];
  sem_req_t    cur_req;

  logic              binary_sel;
  int                sem_val;
  int                queued;
  logic [ID_W-1:0]   wait_ids[MAX_WAITERS];
  logic [PRIO_W-1:0] wait_prios[MAX_WAITERS];

  int  in_gap;
  int  in_calm = 0;
  int  out_stall;
  int  out_calm = 0;
  int  settle;
  int  accepted;
  int  hold_left;
  logic hold_done;
  int  cycles = 0;
  int  mismatches = 0;
  int  results_seen;
  logic holding;

  sem_result_t got;
  sem_result_t want;

  priority_semaphore_wait_queue_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic sem_result_t semaphore_step(logic mode, logic [ID_W-1:0] id,
                                                 logic [PRIO_W-1:0] prio_in);
    sem_result_t r;
    logic [PRIO_W-1:0] prio;
    int pos;
    int k;
    r = '0;
    prio = (prio_in > PRIO_LAST) ? PRIO_LAST : prio_in;
    if (mode == MODE_WAIT) begin
      if (sem_val > 0) begin
        sem_val = binary_sel ? 0 : sem_val - 1;
        r.granted = 1'b1;
      end else if (queued >= MAX_WAITERS) begin
        r.full_err = 1'b1;
      end else begin
        if (!binary_sel && sem_val > SEM_FLOOR) sem_val = sem_val - 1;
        pos = 0;
        while (pos < queued && wait_prios[pos] <= prio) pos++;
        for (k = queued; k > pos; k--) begin
          wait_ids[k] = wait_ids[k-1];
          wait_prios[k] = wait_prios[k-1];
        end
        wait_ids[pos] = id;
        wait_prios[pos] = prio;
        queued++;
        r.blocked = 1'b1;
      end
    end else begin
      if (!binary_sel && sem_val < SEM_CEIL) sem_val = sem_val + 1;
      if (queued == 0) begin
        if (binary_sel) sem_val = 1;
      end else if (binary_sel || sem_val <= 0) begin
        r.woken_valid = 1'b1;
        r.woken_id = wait_ids[0];
        r.woken_prio = wait_prios[0];
        for (k = 1; k < queued; k++) begin
          wait_ids[k-1] = wait_ids[k];
          wait_prios[k-1] = wait_prios[k];
        end
        queued--;
      end
    end
    r.waiters_now = queued[TOTAL_W-1:0];
    r.count_now = sem_val[COUNT_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic add_op(logic mode, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    sem_req_t q;
    q = '{kind: REQ_OP, mode: mode, id: id, prio: prio, cfg_idx: 1'b0, cfg_val: '0};
    request_q.push_back(q);
  endtask

  task automatic add_cfg(logic idx, logic [CFG_W-1:0] val);
    sem_req_t q;
    q = '{kind: REQ_CFG, mode: MODE_WAIT, id: '0, prio: '0, cfg_idx: idx, cfg_val: val};
    request_q.push_back(q);
  endtask

  task automatic add_sync();
    sem_req_t q;
    q = '{kind: REQ_SYNC, mode: MODE_WAIT, id: '0, prio: '0, cfg_idx: 1'b0, cfg_val: '0};
    request_q.push_back(q);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result %0d: %s expected %0d, got %0d", results_seen, name, exp_val,
                 act_val);
    end
  endtask

  // Request driver: operations, register writes and quiet points taken in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      in_gap <= 0;
      settle <= 0;
      accepted <= 0;
      binary_sel = 1'b0;
      sem_val = 0;
      queued = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(semaphore_step(cur_req.mode, cur_req.id, cur_req.prio));
        accepted <= accepted + 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cur_req.cfg_idx == CFG_BINARY_MODE) begin
          binary_sel = cur_req.cfg_val[0];
        end else begin
          sem_val = int'(cur_req.cfg_val);
          queued = 0;
        end
      end
      holding = (in_tvalid && !in_tready) || (cfg_valid && !cfg_ready);
      if (!holding) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (request_q.size() == 0) begin
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
        end else begin
          case (request_q[0].kind)
            REQ_OP: begin
              cur_req = request_q.pop_front();
              in_tdata <= IN_TDATA_W'({cur_req.prio, cur_req.id});
              in_tuser <= cur_req.mode;
              in_tvalid <= 1'b1;
              cfg_valid <= 1'b0;
              in_gap <= pick_gap(in_calm);
            end
            REQ_CFG: begin
              cur_req = request_q.pop_front();
              cfg_index <= cur_req.cfg_idx;
              cfg_data <= cur_req.cfg_val;
              cfg_valid <= 1'b1;
              in_tvalid <= 1'b0;
            end
            default: begin
              in_tvalid <= 1'b0;
              cfg_valid <= 1'b0;
              if (outcome_q.size() != 0) begin
                settle <= 0;
              end else if (settle >= SYNC_SETTLE) begin
                void'(request_q.pop_front());
                settle <= 0;
              end else begin
                settle <= settle + 1;
              end
            end
          endcase
        end
      end
    end
  end

  // One long back-pressure stretch early in the random part.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.granted = out_tdata[0];
        got.blocked = out_tdata[1];
        got.woken_valid = out_tdata[2];
        got.woken_id = out_tdata[8:3];
        got.woken_prio = out_tdata[11:9];
        got.full_err = out_tdata[12];
        got.waiters_now = out_tdata[17:13];
        got.count_now = out_tdata[26:18];
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d arrived with none expected: %h", results_seen, out_tdata);
        end else begin
          want = outcome_q.pop_front();
          check_field("granted", want.granted, got.granted);
          check_field("blocked", want.blocked, got.blocked);
          check_field("woken_valid", want.woken_valid, got.woken_valid);
          check_field("woken_id", want.woken_id, got.woken_id);
          check_field("woken_priority", want.woken_prio, got.woken_prio);
          check_field("queue_full_error", want.full_err, got.full_err);
          check_field("waiters_now", want.waiters_now, got.waiters_now);
          check_field("count_now", int'(want.count_now), int'(got.count_now));
        end
      end
      if (hold_left != 0 || out_stall != 0) begin
        out_tready <= 1'b0;
        if (out_stall != 0) out_stall <= out_stall - 1;
      end else if ((out_tvalid && out_tready) || !out_tready) begin
        out_stall <= pick_gap(out_calm);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    automatic int dir_ids[16] = '{0, 63, 5, 6, 7, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 42};
    automatic int dir_prios[16] = '{0, 7, 3, 3, 0, 6, 1, 5, 2, 3, 4, 0, 6, 2, 5, 1};
    int wait_pct;
    logic bin_bit;
    logic [CFG_W-1:0] start_val;

    // Fill the queue past its limit, then wake the most urgent threads.
    add_cfg(CFG_BINARY_MODE, 8'h00);
    add_cfg(CFG_INITIAL_COUNT, 8'h00);
    for (int i = 0; i < 16; i++)
      add_op(MODE_WAIT, ID_W'(dir_ids[i]), PRIO_W'(dir_prios[i]));
    add_op(MODE_WAIT, 6'd33, 3'd4);
    add_op(MODE_SIGNAL, 6'd21, 3'd7);
    add_op(MODE_SIGNAL, 6'd0, 3'd0);
    add_op(MODE_SIGNAL, 6'd63, 3'd6);
    add_sync();
    add_cfg(CFG_INITIAL_COUNT, 8'hFF);
    add_op(MODE_SIGNAL, 6'd1, 3'd1);
    add_op(MODE_WAIT, 6'd2, 3'd2);
    add_sync();
    add_cfg(CFG_BINARY_MODE, 8'hFF);
    add_cfg(CFG_INITIAL_COUNT, 8'h00);
    add_op(MODE_WAIT, 6'd1, 3'd2);
    add_op(MODE_SIGNAL, 6'd3, 3'd0);
    add_op(MODE_SIGNAL, 6'd4, 3'd5);
    add_op(MODE_WAIT, 6'd5, 3'd7);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      add_sync();
      bin_bit = (p < 8) ? p[0] : 1'($urandom_range(0, 1));
      add_cfg(CFG_BINARY_MODE, {7'($urandom_range(0, 127)), bin_bit});
      if (p % 3 != 0) begin
        if (p == 1) start_val = 8'hFF;
        else if (p == 2) start_val = 8'h00;
        else if (p == 4) start_val = 8'h01;
        else if ($urandom_range(0, 3) == 0) start_val = 8'($urandom_range(0, 255));
        else start_val = 8'($urandom_range(0, 4));
        add_cfg(CFG_INITIAL_COUNT, start_val);
      end
      case (p % 4)
        0: wait_pct = 55;
        1: wait_pct = 35;
        2: wait_pct = 80;
        default: wait_pct = 65;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        add_op(($urandom_range(0, 99) < wait_pct) ? MODE_WAIT : MODE_SIGNAL,
               6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (request_q.size() != 0 || in_tvalid || cfg_valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
